// ----- hdl/srwc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// srwc_pkg: shadow register write cache shared definitions
// Entry layout, handshake structs, function and result codes, width helpers.
// ----------------------------------------------------------------------------
package srwc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int SPAN_W  = CNT_W + 2;

	localparam logic [1:0] WMODE_8   = 2'd0;
	localparam logic [1:0] WMODE_16  = 2'd1;
	localparam logic [1:0] WMODE_32  = 2'd2;
	localparam logic [1:0] WMODE_BAD = 2'd3;

	typedef enum logic [2:0] {
		FUNC_READ    = 3'd0,
		FUNC_WRITE   = 3'd1,
		FUNC_COMMIT  = 3'd2,
		FUNC_LOAD    = 3'd3,
		FUNC_REFRESH = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		KIND_REPLY     = 2'd0,
		KIND_BUS_READ  = 2'd1,
		KIND_BUS_WRITE = 2'd2,
		KIND_DONE      = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_WIDTH_MODE  = 2'd0,
		REG_BASE_OFFSET = 2'd1,
		REG_ENTRY_COUNT = 2'd2,
		REG_WO_ENABLE   = 2'd3
	} reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_ACCESS,
		S_LOAD,
		S_COMMIT
	} state_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		logic [1:0]  width_mode;
		logic [30:0] base_offset;
		logic [4:0]  entry_count;
		logic        wo_enable;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  func;
		logic        cached;
		logic [30:0] address;
		logic [1:0]  size;
		logic [31:0] data;
		logic        force_all;
		logic [3:0]  index;
		logic [31:0] in_mask;
		logic [31:0] out_mask;
		logic [31:0] wo_mask;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [30:0] bus_address;
		logic [1:0]  bus_size;
		logic [31:0] value;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [31:0] ic;   // input copy
		logic [31:0] oc;   // output copy
		logic [31:0] lw;   // last written
		logic [31:0] ib;   // input bits
		logic [31:0] ob;   // output bits
		logic [31:0] wob;  // write-only bits
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		entry_t           entry;
	} st_wr_t;

	function automatic logic [31:0] size_mask(input logic [1:0] sz);
		logic [31:0] m;
		case (sz)
			WMODE_8:  m = 32'h0000_00FF;
			WMODE_16: m = 32'h0000_FFFF;
			default:  m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/shadow_register_write_cache_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// shadow_register_write_cache_top: write-back shadow of a device register window
// Read/write: accept, lookup, access; the result is registered out of the access state,
// which waits while the output side stalls; a cached write gives none. Load/refresh:
// accept, load, no result. Commit: accept, walk the used entries, then the done item,
// waiting while the output side stalls. One item at a time; the shared address adder
// and the single entry read port set the pace.
// Reset clears configuration, all entries and the sequencer to zero/idle.
// ----------------------------------------------------------------------------
module shadow_register_write_cache_top
	import srwc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	// configuration
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// input items
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// func
	input  wire logic [2:0]   s_tuser,
	// cached, address, size, data, force_all, index, in_mask, out_mask, wo_mask
	input  wire logic [167:0] s_tdata,
	// result items
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// kind
	output logic [1:0]        m_tuser,
	// bus_address, bus_size, value
	output logic [71:0]       m_tdata,
	output logic              m_tlast
);

	cfg_t    cfg_q;
	item_t   s_item;
	result_t m_result;
	logic    cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_t'(paddr[3:2]))
				REG_WIDTH_MODE:  cfg_q.width_mode  <= pwdata[1:0];
				REG_BASE_OFFSET: cfg_q.base_offset <= pwdata[30:0];
				REG_ENTRY_COUNT: cfg_q.entry_count <= pwdata[4:0];
				REG_WO_ENABLE:   cfg_q.wo_enable   <= pwdata[0];
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_t'(paddr[3:2]))
			REG_WIDTH_MODE:  prdata = {30'd0, cfg_q.width_mode};
			REG_BASE_OFFSET: prdata = {1'b0, cfg_q.base_offset};
			REG_ENTRY_COUNT: prdata = {27'd0, cfg_q.entry_count};
			REG_WO_ENABLE:   prdata = {31'd0, cfg_q.wo_enable};
			default:         prdata = '0;
		endcase
	end

	assign s_item.func      = s_tuser;
	assign s_item.cached    = s_tdata[0];
	assign s_item.address   = s_tdata[31:1];
	assign s_item.size      = s_tdata[33:32];
	assign s_item.data      = s_tdata[65:34];
	assign s_item.force_all = s_tdata[66];
	assign s_item.index     = s_tdata[70:67];
	assign s_item.in_mask   = s_tdata[102:71];
	assign s_item.out_mask  = s_tdata[134:103];
	assign s_item.wo_mask   = s_tdata[166:135];

	srwc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_valid  (s_tvalid),
		.s_ready  (s_tready),
		.s_item   (s_item),
		.m_valid  (m_tvalid),
		.m_ready  (m_tready),
		.m_result (m_result)
	);

	assign m_tuser = m_result.kind;
	assign m_tlast = m_result.last;
	assign m_tdata = {7'd0, m_result.value, m_result.bus_size, m_result.bus_address};

endmodule
`default_nettype wire

// ----- hdl/srwc_alu.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// srwc_alu: shared address adder
// One 31-bit add/subtract with a carry/borrow bit, used for the window lookup and write-back addresses.
// ----------------------------------------------------------------------------
module srwc_alu
	import srwc_pkg::*;
(
	input  wire alu_op_t     op,
	input  wire logic [30:0] a,
	input  wire logic [30:0] b,
	output logic [31:0]      res
);

	// bit 31 is the borrow on subtract, the carry on add
	always_comb begin
		if (op == ALU_SUB) begin
			res = {1'b0, a} - {1'b0, b};
		end else begin
			res = {1'b0, a} + {1'b0, b};
		end
	end

endmodule
`default_nettype wire

// ----- hdl/srwc_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// srwc_store: entry register file
// Per-entry copies and bit masks, one read index and one write per cycle.
// ----------------------------------------------------------------------------
module srwc_store
	import srwc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] rd_idx,
	output entry_t                rd_entry,
	input  wire st_wr_t           wr
);

	entry_t mem_q [ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				mem_q[i] <= '0;
			end
		end else if (wr.en) begin
			mem_q[wr.idx] <= wr.entry;
		end
	end

	assign rd_entry = mem_q[rd_idx];

endmodule
`default_nettype wire

// ----- hdl/srwc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// srwc_ctrl: sequencer
// Lookup, access, load and commit walk around the shared adder; output register.
// ----------------------------------------------------------------------------
module srwc_ctrl
	import srwc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  s_valid,
	output logic       s_ready,
	input  wire item_t s_item,
	output logic       m_valid,
	input  wire logic  m_ready,
	output result_t    m_result
);

	state_t            state_q, state_d;
	item_t             item_q;
	logic              hit_q, hit_d;
	logic [IDX_W-1:0]  e_q, e_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              out_valid_q;
	result_t           res_q, res_d;
	logic              put;
	logic              out_free;

	alu_op_t           alu_op;
	logic [30:0]       alu_a, alu_b;
	logic [31:0]       alu_res;

	logic [IDX_W-1:0]  rd_idx;
	entry_t            rd_entry;
	entry_t            new_entry;
	st_wr_t            st_wr;

	logic [31:0]       wm;
	logic [CNT_W-1:0]  n_used;
	logic [SPAN_W-1:0] span;
	logic [1:0]        sz;
	logic [31:0]       ld_data;
	logic [31:0]       ld_ib, ld_ob;
	logic              in_range;
	logic              dirty;
	logic [30:0]       e_full;

	srwc_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	srwc_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (rd_idx),
		.rd_entry (rd_entry),
		.wr       (st_wr)
	);

	assign wm       = size_mask(cfg.width_mode);
	assign sz       = (item_q.size == WMODE_BAD) ? WMODE_32 : item_q.size;
	assign ld_data  = item_q.data & wm;
	assign ld_ib    = item_q.in_mask & wm;
	assign ld_ob    = item_q.out_mask & wm;
	assign in_range = 32'(item_q.index) < ENTRIES;
	assign out_free = !out_valid_q || m_ready;
	assign dirty    = item_q.force_all || (((rd_entry.oc ^ rd_entry.lw) & rd_entry.ob) != '0);
	assign e_full   = alu_res[30:0] >> cfg.width_mode;

	always_comb begin
		if (cfg.width_mode == WMODE_BAD) begin
			n_used = '0;
		end else if (32'(cfg.entry_count) > ENTRIES) begin
			n_used = CNT_W'(ENTRIES);
		end else begin
			n_used = CNT_W'(cfg.entry_count);
		end
	end

	// window size in bytes; n_used is zero when width_mode is invalid
	assign span = {2'b00, n_used} << cfg.width_mode;

	always_comb begin
		unique case (state_q)
			S_ACCESS: rd_idx = e_q;
			S_COMMIT: rd_idx = cnt_q[IDX_W-1:0];
			default:  rd_idx = IDX_W'(item_q.index);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			hit_q       <= 1'b0;
			e_q         <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			hit_q   <= hit_d;
			e_q     <= e_d;
			if (put) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_valid && s_ready) begin
			item_q <= s_item;
		end
		if (put) begin
			res_q <= res_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		hit_d     = hit_q;
		e_d       = e_q;
		put       = 1'b0;
		res_d     = '0;
		alu_op    = ALU_SUB;
		alu_a     = item_q.address;
		alu_b     = cfg.base_offset;
		new_entry = rd_entry;
		st_wr.en    = 1'b0;
		st_wr.idx   = rd_idx;
		st_wr.entry = rd_entry;
		s_ready   = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					cnt_d = '0;
					case (s_item.func)
						FUNC_READ, FUNC_WRITE:   state_d = S_LOOKUP;
						FUNC_COMMIT:             state_d = S_COMMIT;
						FUNC_LOAD, FUNC_REFRESH: state_d = S_LOAD;
						default:                 state_d = S_IDLE;
					endcase
				end
			end

			S_LOOKUP: begin
				// address - base: borrow set means below the window
				hit_d = item_q.cached && (item_q.size == cfg.width_mode) &&
					(cfg.width_mode != WMODE_BAD) && !alu_res[31] &&
					(alu_res[30:0] < 31'(span));
				e_d     = IDX_W'(e_full);
				state_d = S_ACCESS;
			end

			S_ACCESS: begin
				res_d.bus_address = item_q.address;
				res_d.bus_size    = sz;
				res_d.last        = 1'b1;
				if (item_q.func == FUNC_READ) begin
					if (hit_q) begin
						res_d.kind  = KIND_REPLY;
						res_d.value = rd_entry.ic & wm;
					end else begin
						res_d.kind  = KIND_BUS_READ;
					end
					if (out_free) begin
						put     = 1'b1;
						state_d = S_IDLE;
					end
				end else if (hit_q) begin
					new_entry.oc = item_q.data & wm;
					new_entry.ic = (rd_entry.ic & ~rd_entry.ob) |
						(item_q.data & wm & rd_entry.ob);
					st_wr.en    = 1'b1;
					st_wr.entry = new_entry;
					state_d     = S_IDLE;
				end else begin
					res_d.kind  = KIND_BUS_WRITE;
					res_d.value = item_q.data & size_mask(sz);
					if (out_free) begin
						put     = 1'b1;
						state_d = S_IDLE;
					end
				end
			end

			S_LOAD: begin
				if (item_q.func == FUNC_LOAD) begin
					new_entry.ib  = ld_ib;
					new_entry.ob  = ld_ob;
					new_entry.wob = item_q.wo_mask & wm;
					if ((ld_ib | ld_ob) != '0) begin
						new_entry.ic = ld_data;
						new_entry.oc = ld_data;
						new_entry.lw = ~ld_data;
					end else begin
						// unused entry: output copy is left alone
						new_entry.ic = '0;
						new_entry.lw = '0;
					end
				end else if (rd_entry.ib != '0) begin
					new_entry.ic = ld_data;
					new_entry.oc = ld_data;
				end
				st_wr.en    = in_range;
				st_wr.entry = new_entry;
				state_d     = S_IDLE;
			end

			S_COMMIT: begin
				alu_op = ALU_ADD;
				alu_a  = cfg.base_offset;
				alu_b  = 31'(cnt_q) << cfg.width_mode;
				if (cnt_q == n_used) begin
					res_d.kind = KIND_DONE;
					res_d.last = 1'b1;
					if (out_free) begin
						put     = 1'b1;
						state_d = S_IDLE;
					end
				end else if (dirty) begin
					res_d.kind        = KIND_BUS_WRITE;
					res_d.bus_address = alu_res[30:0];
					res_d.bus_size    = cfg.width_mode;
					res_d.value       = rd_entry.oc & wm;
					if (cfg.wo_enable) begin
						new_entry.ic = rd_entry.ic & ~rd_entry.wob;
						new_entry.oc = rd_entry.oc & ~rd_entry.wob;
					end
					new_entry.lw = new_entry.oc;
					if (out_free) begin
						put         = 1'b1;
						st_wr.en    = 1'b1;
						st_wr.entry = new_entry;
						cnt_d       = cnt_q + 1'b1;
					end
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end

			default: state_d = S_IDLE;
		endcase
	end

	assign m_valid  = out_valid_q;
	assign m_result = res_q;

	a_cnt_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COMMIT |-> cnt_q <= n_used)
		else $error("commit walk ran past the used entries");

	a_wr_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st_wr.en |-> state_q != S_IDLE && state_q != S_LOOKUP)
		else $error("entry written outside an access, load or commit step");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		put && res_d.last |=> state_q == S_IDLE)
		else $error("final result issued without returning to idle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		put |-> out_free)
		else $error("output register overwritten while holding an item");

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: shadow register write cache testbench
// Drives request items from a pending queue and applies register settings over
// APB between phases. It predicts every result item from its own shadow of the
// entry store and checks each item that leaves the block against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import srwc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 8;
	localparam int MAX_NOTES   = 40;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [3:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// func
	logic [2:0]   s_tuser = '0;
	// cached, address, size, data, force_all, index, in_mask, out_mask, wo_mask
	logic [167:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// kind
	logic [1:0]   m_tuser;
	// bus_address, bus_size, value
	logic [71:0]  m_tdata;
	logic         m_tlast;

	shadow_register_write_cache_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// register copies as last written
	logic [1:0]  cfg_wmode = WMODE_8;
	logic [30:0] cfg_base = '0;
	logic [4:0]  cfg_count = '0;
	logic        cfg_wo = 1'b0;

	// shadow of the entry store
	logic [31:0] sh_ic[ENTRIES];
	logic [31:0] sh_oc[ENTRIES];
	logic [31:0] sh_lw[ENTRIES];
	logic [31:0] sh_ib[ENTRIES];
	logic [31:0] sh_ob[ENTRIES];
	logic [31:0] sh_wob[ENTRIES];

	item_t   pending[$];
	result_t exp_results[$];

	bit offering = 1'b0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int hold_req = 0;
	int hold_left = 0;
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int commits_seen = 0;
	int cycle_cnt = 0;

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			sh_ic[i] = '0; sh_oc[i] = '0; sh_lw[i] = '0;
			sh_ib[i] = '0; sh_ob[i] = '0; sh_wob[i] = '0;
		end
	end

	function automatic logic [31:0] width_bits(input logic [1:0] w);
		case (w)
			WMODE_8:  return 32'h0000_00FF;
			WMODE_16: return 32'h0000_FFFF;
			default:  return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic void push_result(input logic [1:0] k, input logic [30:0] a,
			input logic [1:0] s, input logic [31:0] v, input logic l);
		result_t r;
		r.kind = k;
		r.bus_address = a;
		r.bus_size = s;
		r.value = v;
		r.last = l;
		exp_results.push_back(r);
	endfunction

	// expected result items for one accepted request item
	function automatic void shadow_step(input item_t it);
		int unsigned n, bytes, e;
		logic [31:0] wm, v;
		logic [1:0] sz;
		longint unsigned a64, base64;
		bit hit;
		n = (cfg_wmode == WMODE_BAD) ? 0 : ((cfg_count > ENTRIES) ? ENTRIES : cfg_count);
		wm = width_bits(cfg_wmode);
		bytes = (cfg_wmode == WMODE_8) ? 1 : ((cfg_wmode == WMODE_16) ? 2 : 4);
		sz = (it.size == WMODE_BAD) ? WMODE_32 : it.size;
		a64 = it.address;
		base64 = cfg_base;
		hit = 1'b0;
		e = 0;
		case (it.func)
			FUNC_READ, FUNC_WRITE: begin
				if (it.cached && it.size == cfg_wmode && cfg_wmode != WMODE_BAD &&
						a64 >= base64 && a64 < base64 + bytes * n) begin
					e = (a64 - base64) / bytes;
					hit = e < ENTRIES;
				end
				if (it.func == FUNC_READ) begin
					if (hit)
						push_result(KIND_REPLY, it.address, sz, sh_ic[e] & wm, 1'b1);
					else
						push_result(KIND_BUS_READ, it.address, sz, 32'h0, 1'b1);
				end else if (hit) begin
					v = it.data & wm;
					sh_oc[e] = v;
					sh_ic[e] = (sh_ic[e] & ~sh_ob[e]) | (v & sh_ob[e]);
				end else begin
					push_result(KIND_BUS_WRITE, it.address, sz, it.data & width_bits(sz), 1'b1);
				end
			end
			FUNC_COMMIT: begin
				for (int unsigned i = 0; i < n; i++) begin
					if (it.force_all || ((sh_oc[i] ^ sh_lw[i]) & sh_ob[i]) != 0) begin
						push_result(KIND_BUS_WRITE, 31'(base64 + i * bytes), cfg_wmode,
							sh_oc[i] & wm, 1'b0);
						if (cfg_wo) begin
							sh_ic[i] = sh_ic[i] & ~sh_wob[i];
							sh_oc[i] = sh_oc[i] & ~sh_wob[i];
						end
						sh_lw[i] = sh_oc[i];
					end
				end
				push_result(KIND_DONE, 31'h0, 2'd0, 32'h0, 1'b1);
			end
			FUNC_LOAD: begin
				if (int'(it.index) < ENTRIES) begin
					sh_ib[it.index] = it.in_mask & wm;
					sh_ob[it.index] = it.out_mask & wm;
					sh_wob[it.index] = it.wo_mask & wm;
					if ((sh_ib[it.index] | sh_ob[it.index]) != 0) begin
						sh_ic[it.index] = it.data & wm;
						sh_oc[it.index] = it.data & wm;
						sh_lw[it.index] = ~(it.data & wm);
					end else begin
						// unused entry: output copy is left alone
						sh_ic[it.index] = '0;
						sh_lw[it.index] = '0;
					end
				end
			end
			FUNC_REFRESH: begin
				if (int'(it.index) < ENTRIES && sh_ib[it.index] != 0) begin
					sh_ic[it.index] = it.data & wm;
					sh_oc[it.index] = it.data & wm;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic item_t make_item(input logic [2:0] f, input logic c,
			input logic [30:0] a, input logic [1:0] s, input logic [31:0] d,
			input logic fa, input logic [3:0] idx, input logic [31:0] im,
			input logic [31:0] om, input logic [31:0] wom);
		item_t it;
		it.func = f; it.cached = c; it.address = a; it.size = s; it.data = d;
		it.force_all = fa; it.index = idx; it.in_mask = im; it.out_mask = om;
		it.wo_mask = wom;
		return it;
	endfunction

	// request driver: new item only once the previous one was taken
	always @(negedge clk) begin
		item_t it;
		if (arst_n && !offering && pending.size() > 0 &&
				$urandom_range(99) >= snd_idle_pct) begin
			it = pending[0];
			s_tuser <= it.func;
			s_tdata <= {1'b0, it.wo_mask, it.out_mask, it.in_mask, it.index,
				it.force_all, it.data, it.size, it.address, it.cached};
			s_tvalid <= 1'b1;
			offering = 1'b1;
		end else if (!offering) begin
			s_tvalid <= 1'b0;
		end
	end

	// result receiver, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_left != 0)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end else if (hold_left != 0) begin
			hold_left--;
		end
	end

	// accept side predicts, result side checks
	always @(posedge clk) begin
		result_t got, want;
		if (s_tvalid && s_tready) begin
			shadow_step(pending.pop_front());
			offering = 1'b0;
			items_sent++;
		end
		if (m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.bus_address = m_tdata[30:0];
			got.bus_size = m_tdata[32:31];
			got.value = m_tdata[64:33];
			got.last = m_tlast;
			results_seen++;
			if (got.kind == KIND_DONE)
				commits_seen++;
			if (exp_results.size() == 0) begin
				errors++;
				if (errors <= MAX_NOTES)
					$display("%0t unexpected result: kind %0d addr %h size %0d value %h last %b",
						$time, got.kind, got.bus_address, got.bus_size, got.value, got.last);
			end else begin
				want = exp_results.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= MAX_NOTES)
						$display({"%0t result mismatch: expected kind %0d addr %h size %0d ",
							"value %h last %b, got kind %0d addr %h size %0d value %h last %b"},
							$time, want.kind, want.bus_address, want.bus_size, want.value,
							want.last, got.kind, got.bus_address, got.bus_size, got.value,
							got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t timeout, %0d results still due", $time, exp_results.size());
			$display("tb_top NOT OK");
			$finish;
		end
	end

	task automatic cfg_write(input reg_t r, input logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			REG_WIDTH_MODE:  cfg_wmode = v[1:0];
			REG_BASE_OFFSET: cfg_base = v[30:0];
			REG_ENTRY_COUNT: cfg_count = v[4:0];
			REG_WO_ENABLE:   cfg_wo = v[0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [1:0] wm, input logic [30:0] base,
			input logic [4:0] cnt, input logic wo);
		cfg_write(REG_WIDTH_MODE, {30'h0, wm});
		cfg_write(REG_BASE_OFFSET, {1'b0, base});
		cfg_write(REG_ENTRY_COUNT, {27'h0, cnt});
		cfg_write(REG_WO_ENABLE, {31'h0, wo});
	endtask

	// loads and refreshes leave no result, so let the block settle after the queues drain
	task automatic wait_drained();
		while (pending.size() != 0 || offering || exp_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic run_phase(input logic [1:0] wm, input logic [30:0] base,
			input logic [4:0] cnt, input logic wo, input int ops, input int snd,
			input int rcv, input int hold);
		int unsigned i, e, bytes, n_use, roll;
		logic [31:0] win;
		logic [1:0] sz;
		wait_drained();
		set_config(wm, base, cnt, wo);
		snd_idle_pct = snd;
		rcv_idle_pct = rcv;
		n_use = (cnt > ENTRIES) ? ENTRIES : cnt;
		bytes = (wm == WMODE_8) ? 1 : ((wm == WMODE_16) ? 2 : 4);
		// fill the window first so cached traffic has something to work on
		for (i = 0; i < n_use; i++) begin
			if ($urandom_range(5) == 0)
				pending.push_back(make_item(FUNC_LOAD, 1'b0, 31'($urandom), 2'($urandom),
					$urandom, 1'b0, 4'(i), 32'h0, 32'h0, $urandom));
			else
				pending.push_back(make_item(FUNC_LOAD, 1'($urandom), 31'($urandom),
					2'($urandom), $urandom, 1'($urandom), 4'(i), $urandom, $urandom,
					$urandom));
		end
		for (i = 0; i < ops; i++) begin
			roll = $urandom_range(99);
			e = (n_use > 0) ? $urandom_range(n_use - 1) : 0;
			win = base + e * bytes + $urandom_range(bytes - 1);
			sz = ($urandom_range(7) == 0) ? 2'($urandom_range(3)) : wm;
			if (roll < 25)
				pending.push_back(make_item(FUNC_READ, 1'b1, win[30:0], sz, $urandom,
					1'($urandom), 4'($urandom), $urandom, $urandom, $urandom));
			else if (roll < 50)
				pending.push_back(make_item(FUNC_WRITE, 1'b1, win[30:0], sz, $urandom,
					1'($urandom), 4'($urandom), $urandom, $urandom, $urandom));
			else if (roll < 62)
				pending.push_back(make_item(3'($urandom_range(1)), 1'($urandom),
					31'($urandom), 2'($urandom), $urandom, 1'($urandom), 4'($urandom),
					$urandom, $urandom, $urandom));
			else if (roll < 77)
				pending.push_back(make_item(FUNC_COMMIT, 1'($urandom), 31'($urandom),
					2'($urandom), $urandom, ($urandom_range(3) == 0), 4'($urandom),
					$urandom, $urandom, $urandom));
			else if (roll < 85)
				pending.push_back(make_item(FUNC_REFRESH, 1'($urandom), 31'($urandom),
					2'($urandom), $urandom, 1'($urandom), 4'($urandom), $urandom,
					$urandom, $urandom));
			else if (roll < 93)
				pending.push_back(make_item(FUNC_LOAD, 1'($urandom), 31'($urandom),
					2'($urandom), $urandom, 1'($urandom), 4'($urandom), $urandom,
					$urandom, $urandom));
			else
				pending.push_back(make_item(3'($urandom_range(5, 7)), 1'($urandom),
					31'($urandom), 2'($urandom), $urandom, 1'($urandom), 4'($urandom),
					$urandom, $urandom, $urandom));
		end
		if (hold != 0)
			hold_req = hold;
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed: 8-bit entries, four in the window, write-only masks on
		set_config(WMODE_8, 31'h100, 5'd4, 1'b1);
		snd_idle_pct = 18;
		rcv_idle_pct = 74;
		pending.push_back(make_item(FUNC_LOAD, 1'b0, 31'h0, WMODE_8, 32'hFFFF_FFFF, 1'b0,
			4'd0, 32'hFFFF_FFFF, 32'h0000_000F, 32'h0000_0003));
		// both masks zero: entry treated as unused
		pending.push_back(make_item(FUNC_LOAD, 1'b0, 31'h0, WMODE_8, 32'h5A, 1'b0,
			4'd1, 32'h0, 32'h0, 32'hFFFF_FFFF));
		pending.push_back(make_item(FUNC_LOAD, 1'b0, 31'h0, WMODE_8, 32'h33, 1'b0,
			4'd2, 32'h0, 32'hFF, 32'hF0));
		// index past entry_count is still accepted
		pending.push_back(make_item(FUNC_LOAD, 1'b0, 31'h0, WMODE_8, 32'hAB, 1'b0,
			4'd15, 32'hFF, 32'hFF, 32'h0));
		pending.push_back(make_item(FUNC_READ, 1'b1, 31'h100, WMODE_8, 32'h0, 1'b0,
			4'd0, 32'h0, 32'h0, 32'h0));
		pending.push_back(make_item(FUNC_READ, 1'b1, 31'h101, WMODE_16, 32'h0, 1'b0,
			4'd0, 32'h0, 32'h0, 32'h0));
		// size 3 goes out as 32 bits
		pending.push_back(make_item(FUNC_READ, 1'b0, 31'h0, WMODE_BAD, 32'h0, 1'b0,
			4'd0, 32'h0, 32'h0, 32'h0));
		pending.push_back(make_item(FUNC_READ, 1'b1, 31'h7FFF_FFFF, WMODE_8, 32'h0, 1'b0,
			4'd0, 32'h0, 32'h0, 32'h0));
		pending.push_back(make_item(FUNC_WRITE, 1'b1, 31'h102, WMODE_8, 32'h1234_56C3,
			1'b0, 4'd0, 32'h0, 32'h0, 32'h0));
		pending.push_back(make_item(FUNC_WRITE, 1'b0, 31'h7FFF_FFFF, WMODE_BAD,
			32'hFFFF_FFFF, 1'b1, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending.push_back(make_item(FUNC_WRITE, 1'b1, 31'h104, WMODE_8, 32'h0000_0177,
			1'b0, 4'd0, 32'h0, 32'h0, 32'h0));
		pending.push_back(make_item(FUNC_COMMIT, 1'b0, 31'h0, WMODE_8, 32'h0, 1'b0,
			4'd0, 32'h0, 32'h0, 32'h0));
		pending.push_back(make_item(FUNC_COMMIT, 1'b0, 31'h0, WMODE_8, 32'h0, 1'b1,
			4'd0, 32'h0, 32'h0, 32'h0));
		pending.push_back(make_item(FUNC_REFRESH, 1'b0, 31'h0, WMODE_8, 32'h11, 1'b0,
			4'd0, 32'h0, 32'h0, 32'h0));
		// no input bits: refresh leaves the entry alone
		pending.push_back(make_item(FUNC_REFRESH, 1'b0, 31'h0, WMODE_8, 32'h22, 1'b0,
			4'd2, 32'h0, 32'h0, 32'h0));
		pending.push_back(make_item(FUNC_READ, 1'b1, 31'h100, WMODE_8, 32'h0, 1'b0,
			4'd0, 32'h0, 32'h0, 32'h0));
		for (int f = 5; f <= 7; f++)
			pending.push_back(make_item(3'(f), 1'($urandom), 31'($urandom), 2'($urandom),
				$urandom, 1'($urandom), 4'($urandom), $urandom, $urandom, $urandom));
		pending.push_back(make_item(FUNC_COMMIT, 1'b0, 31'h0, WMODE_8, 32'h0, 1'b0,
			4'd0, 32'h0, 32'h0, 32'h0));
		pending.push_back(make_item(FUNC_READ, 1'b1, 31'h102, WMODE_8, 32'h0, 1'b0,
			4'd0, 32'h0, 32'h0, 32'h0));

		// top of address space: commit addresses wrap
		run_phase(WMODE_32, 31'h7FFF_FFF0, 5'd8, 1'b1, 10, 18, 74, 0);
		// entry count above the store size saturates
		run_phase(WMODE_16, 31'h0, 5'd31, 1'b0, 10, 74, 18, 0);
		// invalid width mode caches nothing
		run_phase(WMODE_BAD, 31'($urandom), 5'd8, 1'b1, 8, 74, 18, 0);
		run_phase(WMODE_8, 31'h1000, 5'd0, 1'b0, 6, 0, 0, 0);
		// output side holds off long enough to back up the input
		run_phase(WMODE_32, 31'($urandom) & ~31'h3, 5'd5, 1'b0, 18, 0, 0, 150);
		run_phase(WMODE_16, 31'h7FFF_FFFF, 5'd4, 1'b1, 8, 0, 0, 0);

		wait_drained();
		repeat (20) @(negedge clk);
		if (exp_results.size() != 0) begin
			errors++;
			$display("%0t %0d predicted results never arrived", $time, exp_results.size());
		end
		$display("covered %0d request items and %0d result items (%0d commits) over seven",
			items_sent, results_seen, commits_seen);
		$display("register settings, with idling on both sides and a long output stall");
		if (errors == 0) begin
			$display("tb_top OK");
		end else begin
			$display("%0d errors", errors);
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
